/* rtl/tmfa_pkg.sv */
// ----------------------------------------------------------------------------
// tmfa_pkg: shared types and constants of the typed multi-format adder
// Format codes and a helper function used by the adder modules.
// ----------------------------------------------------------------------------
package tmfa_pkg;

	typedef enum logic [2:0] {
		FMT_I16 = 3'd0,
		FMT_I32 = 3'd1,
		FMT_F32 = 3'd2,
		FMT_F64 = 3'd3
	} fmt_t;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_BADFMT = 1'b1;

	// leading zeros of a 56-bit word, 56 when the word is zero
	function automatic logic [6:0] clz56(input logic [55:0] v);
		logic [6:0] n;
		logic       hit;
		n   = 7'd56;
		hit = 1'b0;
		for (int i = 55; i >= 0; i--) begin
			if (!hit && v[i]) begin
				n   = 7'(55 - i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

/* rtl/tmfa_fpadd.sv */
// ----------------------------------------------------------------------------
// tmfa_fpadd: binary32 / binary64 adder datapath
// Round to nearest even, subnormals, infinities, default quiet NaN.
// ----------------------------------------------------------------------------
module tmfa_fpadd (
	input  logic        is_dbl,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] sum
);

	logic        sa, sb, sx, sy, swap, like, lost, ovf, rinc, big;
	logic [10:0] xa, xb, emax, ea, eb, ex, en, d, lim;
	logic [51:0] fa, fb;
	logic [55:0] ma, mb, mx, mn, mn_al;
	logic [56:0] s, s_n;
	logic [55:0] s_al;
	logic [6:0]  lz;
	logic [10:0] sh;
	logic [11:0] e_n, e_r;
	logic [53:0] m, m_r;
	logic        nan_a, nan_b, inf_a, inf_b;

	always_comb begin
		sa   = is_dbl ? a[63] : a[31];
		sb   = is_dbl ? b[63] : b[31];
		xa   = is_dbl ? a[62:52] : {3'b0, a[30:23]};
		xb   = is_dbl ? b[62:52] : {3'b0, b[30:23]};
		fa   = is_dbl ? a[51:0] : {29'b0, a[22:0]};
		fb   = is_dbl ? b[51:0] : {29'b0, b[22:0]};
		emax = is_dbl ? 11'h7ff : 11'h0ff;
		nan_a = (xa == emax) && (fa != '0);
		nan_b = (xb == emax) && (fb != '0);
		inf_a = (xa == emax) && (fa == '0);
		inf_b = (xb == emax) && (fb == '0);

		// significands with guard, round, sticky
		ma = is_dbl ? {xa != '0, fa, 3'b0} : {29'b0, xa != '0, fa[22:0], 3'b0};
		mb = is_dbl ? {xb != '0, fb, 3'b0} : {29'b0, xb != '0, fb[22:0], 3'b0};
		ea = (xa == '0) ? 11'd1 : xa;
		eb = (xb == '0) ? 11'd1 : xb;

		swap = (eb > ea) || ((eb == ea) && (mb > ma));
		mx = swap ? mb : ma;
		mn = swap ? ma : mb;
		ex = swap ? eb : ea;
		en = swap ? ea : eb;
		sx = swap ? sb : sa;
		sy = swap ? sa : sb;

		// alignment
		d    = ex - en;
		lost = |(mn & ~({56{1'b1}} << d));
		if (d > (is_dbl ? 11'd56 : 11'd27))
			mn_al = {55'b0, |mn};
		else
			mn_al = (mn >> d) | {55'b0, lost};

		like = (sx == sy);
		s    = like ? ({1'b0, mx} + {1'b0, mn_al}) : ({1'b0, mx} - {1'b0, mn_al});

		// normalize
		ovf  = is_dbl ? s[56] : s[27];
		s_al = is_dbl ? s[55:0] : (s[55:0] << 29);
		lz   = tmfa_pkg::clz56(s_al);
		lim  = ex - 11'd1;
		sh   = ({4'b0, lz} < lim) ? {4'b0, lz} : lim;
		if (ovf) begin
			s_n = {1'b0, s[56:1]} | {56'b0, s[0]};
			e_n = {1'b0, ex} + 12'd1;
		end else begin
			s_n = s << sh;
			e_n = {1'b0, ex} - {1'b0, sh};
		end

		// round to nearest even
		m    = s_n[56:3];
		rinc = (s_n[2:0] > 3'd4) || ((s_n[2:0] == 3'd4) && m[0]);
		m_r  = m + {53'b0, rinc};
		big  = is_dbl ? m_r[53] : m_r[24];
		e_r  = big ? e_n + 12'd1 : e_n;
		if (big)
			m_r = m_r >> 1;

		// result selection
		if (nan_a || nan_b || (inf_a && inf_b && (sa != sb)))
			sum = is_dbl ? 64'h7ff8000000000000 : 64'h000000007fc00000;
		else if (inf_a || inf_b)
			sum = is_dbl ? {inf_a ? sa : sb, 11'h7ff, 52'b0}
			             : {32'b0, inf_a ? sa : sb, 8'hff, 23'b0};
		else if (s == '0)
			sum = like ? (is_dbl ? {sx, 63'b0} : {32'b0, sx, 31'b0}) : 64'b0;
		else if (e_r >= {1'b0, emax})
			sum = is_dbl ? {sx, 11'h7ff, 52'b0} : {32'b0, sx, 8'hff, 23'b0};
		else if (is_dbl)
			sum = {sx, m_r[52] ? e_r[10:0] : 11'b0, m_r[51:0]};
		else
			sum = {32'b0, sx, m_r[23] ? e_r[7:0] : 8'b0, m_r[22:0]};
	end

endmodule

/* rtl/typed_multi_format_adder.sv */
// ----------------------------------------------------------------------------
// typed_multi_format_adder: int16 / int32 / binary32 / binary64 adder
// Path: input reg, then result reg; a held output keeps the request in the input reg.
// Throughput: one request per cycle when not stalled; datapath is one registered pass.
// Reset: arst_n clears the valid flags of both registers; payload is not reset.
// Unknown format codes give status 1 and a zero sum.
// ----------------------------------------------------------------------------
module typed_multi_format_adder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  action,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] sum_bits,
	output logic        status
);

	// input register
	logic        v_s1;
	logic [2:0]  act_s1;
	logic [63:0] a_s1, b_s1;
	// result register
	logic        v_q;
	logic [63:0] sum_q;
	logic        st_q;

	logic        out_free, adv;
	logic [63:0] fp_sum, sum_c;
	logic        st_c;
	logic [31:0] add32;

	// result slot can take a new value when empty or being drained
	assign out_free  = !v_q || !rsp_stall;
	assign adv       = v_s1 && out_free;
	// input register holds its request only while it cannot move on
	assign req_stall = v_s1 && !out_free;

	tmfa_fpadd u_fpadd (
		.is_dbl (act_s1 == tmfa_pkg::FMT_F64),
		.a      (a_s1),
		.b      (b_s1),
		.sum    (fp_sum)
	);

	always_comb begin
		add32 = a_s1[31:0] + b_s1[31:0];
		st_c  = tmfa_pkg::STATUS_OK;
		case (act_s1)
			tmfa_pkg::FMT_I16: sum_c = {48'b0, add32[15:0]};
			tmfa_pkg::FMT_I32: sum_c = {32'b0, add32};
			tmfa_pkg::FMT_F32,
			tmfa_pkg::FMT_F64: sum_c = fp_sum;
			default: begin
				sum_c = 64'b0;
				st_c  = tmfa_pkg::STATUS_BADFMT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!req_stall) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			act_s1 <= action;
			a_s1   <= operand_a;
			b_s1   <= operand_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (out_free) begin
			v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_q <= sum_c;
			st_q  <= st_c;
		end
	end

	assign rsp_valid = v_q;
	assign sum_bits  = sum_q;
	assign status    = st_q;

	// an error result never carries a sum
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> sum_bits == 64'b0)
		else $error("error result with nonzero sum");

	// back-pressure only when both registers are full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> v_s1 && rsp_valid && rsp_stall)
		else $error("request stalled with room in the pipe");

	// a request leaving the input register shows up as a result
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !req_stall |=> rsp_valid)
		else $error("request lost between stages");

endmodule
